// ===== sv/rrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Rice residual decoder package
// Shared types and constants for the controller, the datapath and the top.
// ----------------------------------------------------------------------------
package rrd_pkg;

	// Bitstream word width and the width of a bit position within a word.
	localparam int WORD_W = 32;
	localparam int POS_W  = 6;

	// Configuration register widths.
	localparam int K_W     = 5;
	localparam int COUNT_W = 16;
	localparam int OFFS_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RICE_PARAM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VALUE_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 2'd2;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // take in a new stream word
		logic step;   // run one decode step on the current word
		logic flush;  // send the held result out as the last of its word
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hold_valid;   // a decoded result waits in the hold register
		logic out_blocked;  // output register is full and stalled
		logic word_done;    // the step under way finishes the current word
	} dp_sts_t;

endpackage

// ===== sv/rice_residual_decoder_unit.sv =====
// Latency: a decoded result waits in a hold register until the next code of
// its word completes or the flush cycle of its word, then shows on the outputs.
// Flow: one stream word at a time runs through a load, its decode steps
// (one per unary run and one per remainder piece) and a flush; output stalls hold it.
// Reset: arst_n clears all control state at once; the registers return to
// k = 0, count = 1, offset = 0 and the next word starts a new job.
// ----------------------------------------------------------------------------
// Rice residual decoder unit
// Decodes signed Rice codes from 32-bit big-endian stream words and emits
// one residual per item with job and word end markers.
// ----------------------------------------------------------------------------
module rice_residual_decoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rrd_pkg::WORD_W-1:0]        stream_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rrd_pkg::WORD_W-1:0] residual,
	output logic                              last_of_block,
	output logic                              last_in_word,
	output logic [rrd_pkg::POS_W-1:0]         end_bit_offset,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rrd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rrd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rrd_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	// Sequencer.
	rrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Decode datapath and output register.
	rrd_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.stream_word    (stream_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.residual       (residual),
		.last_of_block  (last_of_block),
		.last_in_word   (last_in_word),
		.end_bit_offset (end_bit_offset)
	);

endmodule

// ===== sv/rrd_datapath.sv =====
// ----------------------------------------------------------------------------
// Rice residual decoder datapath
// Holds the configuration, the current word, the partial code state, one
// held result and the output register. Runs one decode step per command.
// ----------------------------------------------------------------------------
module rrd_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rrd_pkg::ctrl_cmd_t                cmd,
	output rrd_pkg::dp_sts_t                  sts,
	input  logic                              cfg_we,
	input  logic [rrd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rrd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [rrd_pkg::WORD_W-1:0]        stream_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rrd_pkg::WORD_W-1:0] residual,
	output logic                              last_of_block,
	output logic                              last_in_word,
	output logic [rrd_pkg::POS_W-1:0]         end_bit_offset
);
	import rrd_pkg::*;

	// Leading zero count by halving, five dependent steps.
	function automatic logic [4:0] lzc(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] t;
		logic [4:0]        n;
		t = v;
		n = '0;
		if (t[31:16] == '0) begin
			n[4] = 1'b1;
			t = t << 16;
		end
		if (t[31:24] == '0) begin
			n[3] = 1'b1;
			t = t << 8;
		end
		if (t[31:28] == '0) begin
			n[2] = 1'b1;
			t = t << 4;
		end
		if (t[31:30] == '0) begin
			n[1] = 1'b1;
			t = t << 2;
		end
		if (t[31] == 1'b0) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

	// Configuration registers.
	logic [K_W-1:0]     k_q;
	logic [COUNT_W-1:0] count_q;
	logic [OFFS_W-1:0]  offs_q;

	// Decode state.
	logic [WORD_W-1:0]  cur_q;
	logic [POS_W-1:0]   pos_q;
	logic [WORD_W-1:0]  quot_q;
	logic [WORD_W-1:0]  rem_q;
	logic [K_W-1:0]     bits_left_q;
	logic               rphase_q;
	logic [COUNT_W-1:0] values_left_q;
	logic               first_pend_q;

	// Held result and output register.
	logic               hold_valid_q;
	logic [WORD_W-1:0]  hold_res_q;
	logic               hold_lob_q;
	logic [POS_W-1:0]   hold_end_q;
	logic               out_valid_q;
	logic [WORD_W-1:0]  out_res_q;
	logic               out_lob_q;
	logic               out_liw_q;
	logic [POS_W-1:0]   out_end_q;

	// Step results.
	logic [POS_W-1:0]   avail;
	logic [4:0]         lz;
	logic [K_W-1:0]     n_bits;
	logic [POS_W-1:0]   pos_n;
	logic [WORD_W-1:0]  cur_n;
	logic [WORD_W-1:0]  quot_n;
	logic [WORD_W-1:0]  rem_n;
	logic [K_W-1:0]     bl_n;
	logic               rph_n;
	logic               emit;
	logic               last;
	logic [WORD_W-1:0]  u;
	logic [WORD_W-1:0]  res;
	logic [COUNT_W-1:0] vl_n;
	logic               push;

	// One decode step: either a unary run or a piece of the remainder.
	always_comb begin
		avail  = 6'd32 - pos_q;
		lz     = lzc(cur_q);
		n_bits = (avail > {1'b0, bits_left_q}) ? bits_left_q : avail[K_W-1:0];
		pos_n  = pos_q;
		cur_n  = cur_q;
		quot_n = quot_q;
		rem_n  = rem_q;
		bl_n   = bits_left_q;
		rph_n  = rphase_q;
		emit   = 1'b0;
		if (!rphase_q) begin
			if (cur_q != '0) begin
				quot_n = quot_q + {27'd0, lz};
				pos_n  = pos_q + {1'b0, lz} + 6'd1;
				cur_n  = (cur_q << lz) << 1;
				rem_n  = '0;
				if (k_q == '0) begin
					emit = 1'b1;
				end else begin
					rph_n = 1'b1;
					bl_n  = k_q;
				end
			end else begin
				quot_n = quot_q + {26'd0, avail};
				pos_n  = 6'd32;
				cur_n  = '0;
			end
		end else begin
			rem_n = (rem_q << n_bits) | (cur_q >> (6'd32 - {1'b0, n_bits}));
			bl_n  = bits_left_q - n_bits;
			pos_n = pos_q + {1'b0, n_bits};
			cur_n = cur_q << n_bits;
			if (bl_n == '0) begin
				rph_n = 1'b0;
				emit  = 1'b1;
			end
		end
		// Rebuild the folded value and undo the zigzag mapping.
		u    = (quot_n << k_q) | rem_n;
		res  = (u >> 1) ^ {WORD_W{u[0]}};
		vl_n = values_left_q - 16'd1;
		last = (vl_n == '0);
	end

	// Status toward the controller.
	always_comb begin
		sts.hold_valid  = hold_valid_q;
		sts.out_blocked = out_valid_q && out_stall;
		sts.word_done   = (pos_n == 6'd32) || (emit && last);
	end

	// The output register is loaded from the hold register.
	assign push = hold_valid_q && ((cmd.step && emit) || cmd.flush);

	// Control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q           <= '0;
			count_q       <= 16'd1;
			offs_q        <= '0;
			pos_q         <= '0;
			quot_q        <= '0;
			rem_q         <= '0;
			bits_left_q   <= '0;
			rphase_q      <= 1'b0;
			values_left_q <= '0;
			first_pend_q  <= 1'b1;
			hold_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_RICE_PARAM:   k_q     <= cfg_data[K_W-1:0];
					CFG_VALUE_COUNT:  count_q <= cfg_data;
					CFG_START_OFFSET: offs_q  <= cfg_data[OFFS_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				if (first_pend_q) begin
					pos_q         <= {1'b0, offs_q};
					values_left_q <= count_q;
					first_pend_q  <= 1'b0;
				end else begin
					pos_q <= '0;
				end
			end
			if (cmd.step) begin
				pos_q <= pos_n;
				if (emit) begin
					quot_q        <= '0;
					rem_q         <= '0;
					bits_left_q   <= '0;
					rphase_q      <= 1'b0;
					values_left_q <= vl_n;
					hold_valid_q  <= 1'b1;
					if (last) begin
						first_pend_q <= 1'b1;
					end
				end else begin
					quot_q      <= quot_n;
					rem_q       <= rem_n;
					bits_left_q <= bl_n;
					rphase_q    <= rph_n;
				end
			end
			if (cmd.flush) begin
				hold_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Word and result payload, no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= first_pend_q ? (stream_word << offs_q) : stream_word;
		end
		if (cmd.step) begin
			cur_q <= cur_n;
			if (emit) begin
				hold_res_q <= res;
				hold_lob_q <= last;
				hold_end_q <= pos_n;
			end
		end
		if (push) begin
			out_res_q <= hold_res_q;
			out_lob_q <= hold_lob_q;
			out_liw_q <= cmd.flush;
			out_end_q <= hold_end_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign residual       = out_res_q;
	assign last_of_block  = out_lob_q;
	assign last_in_word   = out_liw_q;
	assign end_bit_offset = out_end_q;

	// The bit position never runs past the end of a word.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 6'd32)
		else $error("bit position beyond word end");

	// A remainder under way always has bits still to read.
	a_rem_bits: assert property (@(posedge clk) disable iff (!arst_n)
		rphase_q |-> bits_left_q != '0)
		else $error("remainder phase with no bits left");

	// A flush of a held result shows it as the last item of its word.
	a_flush_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush && hold_valid_q |=> out_valid_q && out_liw_q && !hold_valid_q)
		else $error("flush did not present the held result");

	// A step never runs while the output register is full and stalled.
	a_step_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !(out_valid_q && out_stall))
		else $error("decode step while output blocked");

endmodule

// ===== sv/rrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Rice residual decoder controller
// Sequences one stream word at a time: load, decode steps, flush.
// ----------------------------------------------------------------------------
module rrd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rrd_pkg::dp_sts_t    sts,
	output rrd_pkg::ctrl_cmd_t  cmd
);
	import rrd_pkg::*;

	state_t state_q;
	state_t state_n;

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_n = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!sts.out_blocked && sts.word_done) begin
					state_n = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!sts.hold_valid || !sts.out_blocked) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Commands and input handshake.
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.step = !sts.out_blocked;
			end
			ST_FLUSH: begin
				cmd.flush = sts.hold_valid && !sts.out_blocked;
			end
			default: ;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

// ===== tb/rice_residual_decoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Rice residual decoder unit testbench
// Drives stream words into the decoder and decodes the same bits in a
// behavioral model of its own. Every residual item that leaves the block is
// checked against the oldest decoded value still waiting. A short table of
// directed words and register writes comes first. Random phases with new
// register settings follow; the last phase and the close of its job run
// with no idling.
// ----------------------------------------------------------------------------
module rice_residual_decoder_unit_tb;

	import rrd_pkg::*;

	// Write to an index that the block does not decode.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	// Cycles to let pass once nothing is waiting, so that a word with no
	// result has left the block (its load, up to 32 decode steps and its flush).
	localparam int SETTLE_CYCLES = 100;

	// Several times the slowest run: about 480 words at 32 results each,
	// with the longest receiver stall on every result, at 8 time units per cycle.
	localparam int RUN_LIMIT = 8 * 1_500_000;

	localparam int DIR_ROWS = 26;

	// One decoded residual item.
	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              blk_last;
		logic              word_last;
		logic [POS_W-1:0]  bit_pos;
	} rice_res_t;

	typedef enum logic {
		ROW_WORD,
		ROW_CFG
	} row_kind_t;

	// One row of the directed table.
	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [WORD_W-1:0]     word;
		bit                    typed;
		rice_res_t             want;
	} dir_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [WORD_W-1:0]         stream_word;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [WORD_W-1:0]  residual;
	logic                      last_of_block;
	logic                      last_in_word;
	logic [POS_W-1:0]          end_bit_offset;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	// Decoded residuals still waiting to leave the block.
	rice_res_t queued_residuals[$];
	int        bad_items = 0;

	// Idling switches for the sender and the receiver.
	bit in_gaps  = 1'b1;
	bit out_gaps = 1'b1;

	// Register copies and decoder state of the model, at their reset values.
	logic [K_W-1:0]     k_reg     = '0;
	logic [COUNT_W-1:0] count_reg = 16'd1;
	logic [OFFS_W-1:0]  offs_reg  = '0;
	logic [WORD_W-1:0]  quot_acc  = '0;
	logic [WORD_W-1:0]  rem_acc   = '0;
	int                 rem_left  = 0;
	bit                 in_rem    = 1'b0;
	logic [COUNT_W-1:0] vals_left = '0;
	bit                 job_start = 1'b1;

	// The directed table. Typed results are read straight off the code.
	dir_row_t dir_rows [DIR_ROWS] = '{
		// After reset: k = 0, one residual per job, offset 0.
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'h8000_0000, 1'b1,
			'{32'h0000_0000, 1'b1, 1'b1, 6'd1}},
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'h0000_0001, 1'b1,
			'{32'hFFFF_FFF0, 1'b1, 1'b1, 6'd32}},
		// A word of zeros completes no code; the run carries on.
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'h0000_0000, 1'b0, '0},
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'h8000_0000, 1'b1,
			'{32'h0000_0010, 1'b1, 1'b1, 6'd1}},
		// k = 30, the largest k that this bench uses.
		'{ROW_CFG, CFG_RICE_PARAM, 16'd30, 32'h0, 1'b0, '0},
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'hFFFF_FFFF, 1'b1,
			'{32'hE000_0000, 1'b1, 1'b1, 6'd31}},
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'h7FFF_FFFF, 1'b1,
			'{32'hC000_0000, 1'b1, 1'b1, 6'd32}},
		// Remainder across a word boundary; the value wraps to the extremes.
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'h1FFF_FFFF, 1'b0, '0},
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'h8000_0000, 1'b1,
			'{32'h7FFF_FFFF, 1'b1, 1'b1, 6'd2}},
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'h1FFF_FFFF, 1'b0, '0},
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'hC000_0000, 1'b1,
			'{32'h8000_0000, 1'b1, 1'b1, 6'd2}},
		// Largest start offset.
		'{ROW_CFG, CFG_START_OFFSET, 16'd31, 32'h0, 1'b0, '0},
		'{ROW_CFG, CFG_RICE_PARAM, 16'd0, 32'h0, 1'b0, '0},
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'h0000_0001, 1'b1,
			'{32'h0000_0000, 1'b1, 1'b1, 6'd32}},
		// A job of three with a remainder that starts near the word end.
		'{ROW_CFG, CFG_START_OFFSET, 16'd28, 32'h0, 1'b0, '0},
		'{ROW_CFG, CFG_RICE_PARAM, 16'd8, 32'h0, 1'b0, '0},
		'{ROW_CFG, CFG_VALUE_COUNT, 16'd3, 32'h0, 1'b0, '0},
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'h0000_000F, 1'b0, '0},
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'hF8A5_C3E1, 1'b0, '0},
		// A write to an unused index changes nothing.
		'{ROW_CFG, CFG_UNUSED_IDX, 16'hFFFF, 32'h0, 1'b0, '0},
		// New k between words of a job.
		'{ROW_CFG, CFG_RICE_PARAM, 16'd4, 32'h0, 1'b0, '0},
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'h0000_000F, 1'b0, '0},
		'{ROW_CFG, CFG_RICE_PARAM, 16'd1, 32'h0, 1'b0, '0},
		'{ROW_WORD, CFG_RICE_PARAM, 16'h0000, 32'hA5A5_A5A5, 1'b0, '0},
		// Largest count, replaced before another job can load it.
		'{ROW_CFG, CFG_VALUE_COUNT, 16'hFFFF, 32'h0, 1'b0, '0},
		'{ROW_CFG, CFG_VALUE_COUNT, 16'd1, 32'h0, 1'b0, '0}
	};

	rice_residual_decoder_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.stream_word    (stream_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.residual       (residual),
		.last_of_block  (last_of_block),
		.last_in_word   (last_in_word),
		.end_bit_offset (end_bit_offset),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit.
	initial begin
		#(RUN_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	// Decodes one accepted word and queues the residual items it causes.
	task automatic rice_decode_word(input logic [WORD_W-1:0] w);
		int                pos;
		int                made;
		int                z;
		int                take;
		logic [WORD_W-1:0] probe;
		logic [WORD_W-1:0] piece;
		logic [WORD_W-1:0] u;
		bit                fire;
		bit                last;
		rice_res_t         item;
		pos  = 0;
		made = 0;
		last = 1'b0;
		if (job_start) begin
			pos       = int'(offs_reg);
			vals_left = count_reg;
			job_start = 1'b0;
		end
		while (pos < 32 && made < 32 && !last) begin
			fire = 1'b0;
			if (!in_rem) begin
				// Unary part: count zeros up to the next one bit.
				probe = w << pos;
				if (probe != 0) begin
					z = 0;
					while (!probe[WORD_W-1]) begin
						probe = probe << 1;
						z++;
					end
					quot_acc += z;
					pos      += z + 1;
					rem_acc   = '0;
					if (k_reg == 0) begin
						fire = 1'b1;
					end else begin
						in_rem   = 1'b1;
						rem_left = int'(k_reg);
					end
				end else begin
					quot_acc += 32 - pos;
					pos       = 32;
				end
			end else begin
				// Remainder part: take what this word still holds.
				take = (rem_left < 32 - pos) ? rem_left : 32 - pos;
				if (take > 0) begin
					piece     = (w << pos) >> (32 - take);
					rem_acc   = (rem_acc << take) | piece;
					rem_left -= take;
					pos      += take;
				end
				if (rem_left == 0) begin
					in_rem = 1'b0;
					fire   = 1'b1;
				end
			end
			if (fire) begin
				// Zigzag map of the unsigned code value.
				u               = (quot_acc << k_reg) | rem_acc;
				vals_left       = vals_left - 1'b1;
				last            = (vals_left == 0);
				item.value      = (u >> 1) ^ {WORD_W{u[0]}};
				item.blk_last   = last;
				item.word_last  = 1'b0;
				item.bit_pos    = pos[POS_W-1:0];
				queued_residuals.push_back(item);
				made++;
				quot_acc = '0;
				rem_acc  = '0;
				rem_left = 0;
				in_rem   = 1'b0;
				if (last)
					job_start = 1'b1;
			end
		end
		if (made > 0)
			queued_residuals[queued_residuals.size()-1].word_last = 1'b1;
	endtask

	// Offers one word, with an occasional random gap first while gaps are on, and decodes it on acceptance.
	task automatic push_word(input logic [WORD_W-1:0] w);
		int gap;
		if (in_gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		stream_word <= w;
		do @(posedge clk); while (in_stall);
		rice_decode_word(w);
	endtask

	// Stops the sender, waits for every queued residual, then lets the
	// block finish any word that causes no result.
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (queued_residuals.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register and updates the model's copy.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RICE_PARAM:   k_reg     = data[K_W-1:0];
			CFG_VALUE_COUNT:  count_reg = data;
			CFG_START_OFFSET: offs_reg  = data[OFFS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random stream word: zero runs, single ones, dense, sparse and plain patterns.
	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 32'h1 << $urandom_range(0, 31);
			2, 3:    return $urandom | $urandom;
			4:       return '1;
			5:       return $urandom & $urandom;
			default: return $urandom;
		endcase
	endfunction

	// Receiver: stalls in random bursts while gaps are on.
	initial begin
		int gap;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (out_gaps && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 15);
				out_stall <= 1'b1;
				repeat (gap - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Checks each residual item that leaves the block.
	always @(posedge clk) begin
		rice_res_t seen;
		rice_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {residual, last_of_block, last_in_word, end_bit_offset};
			if (queued_residuals.size() == 0) begin
				bad_items++;
				if (bad_items <= 10)
					$display("unexpected item: residual %h lob %b liw %b offset %0d",
						seen.value, seen.blk_last, seen.word_last, seen.bit_pos);
			end else begin
				want = queued_residuals.pop_front();
				if (seen !== want) begin
					bad_items++;
					if (bad_items <= 10)
						$display("exp/got residual %h/%h lob %b/%b liw %b/%b offset %0d/%0d",
							want.value, seen.value, want.blk_last, seen.blk_last,
							want.word_last, seen.word_last, want.bit_pos, seen.bit_pos);
				end
			end
		end
	end

	// Stimulus.
	initial begin
		logic [CFG_DATA_W-1:0] junk;
		logic [K_W-1:0]        k_new;
		logic [OFFS_W-1:0]     offs_new;
		logic [COUNT_W-1:0]    count_new;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		stream_word = '0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_RICE_PARAM;
		cfg_data    = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table.
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				settle_block();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				push_word(dir_rows[i].word);
				if (dir_rows[i].typed)
					queued_residuals[queued_residuals.size()-1] = dir_rows[i].want;
			end
		end

		// Random phases, each with its own settings and gap pattern; the
		// last phase runs with no gaps.
		for (int p = 0; p < 16; p++) begin
			settle_block();
			in_gaps  = (p < 15) && ($urandom_range(0, 3) != 0);
			out_gaps = (p < 15) && ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) == 0)
				k_new = $urandom_range(0, 1) ? 5'd30 : 5'd0;
			else
				k_new = 5'($urandom_range(0, 30));
			junk = $urandom;
			write_reg(CFG_RICE_PARAM, {junk[CFG_DATA_W-1:K_W], k_new});
			if ($urandom_range(0, 4) == 0)
				count_new = 16'($urandom_range(1, 64));
			else
				count_new = 16'($urandom_range(1, 8));
			write_reg(CFG_VALUE_COUNT, count_new);
			if ($urandom_range(0, 3) == 0)
				offs_new = $urandom_range(0, 1) ? 5'd31 : 5'd0;
			else
				offs_new = 5'($urandom_range(0, 31));
			junk = $urandom;
			write_reg(CFG_START_OFFSET, {junk[CFG_DATA_W-1:OFFS_W], offs_new});
			repeat (25) push_word(pick_word());
		end

		// Last part, no gaps: close the open job.
		in_gaps  = 1'b0;
		out_gaps = 1'b0;
		while (!job_start)
			push_word($urandom | $urandom);
		settle_block();

		if (bad_items == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/rrd_pkg.sv
sv/rrd_datapath.sv
sv/rrd_ctrl.sv
sv/rice_residual_decoder_unit.sv
tb/rice_residual_decoder_unit_tb.sv
